// File: src/mrfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU master frame engine package
// Shared codes, command and status bundles, and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package mrfe_pkg;

    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_READ_PARAM  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_STATUS = 1'd1;

    localparam logic [7:0] READ_PARAM_RESET  = 8'h03;
    localparam logic [7:0] READ_STATUS_RESET = 8'h02;

    localparam logic [1:0] REQ_SEND = 2'd0;
    localparam logic [1:0] REQ_RX   = 2'd1;
    localparam logic [1:0] REQ_END  = 2'd2;

    localparam logic RES_TX     = 1'b0;
    localparam logic RES_REPORT = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_FUNC  = 2'd2;
    localparam logic [1:0] ST_CRC   = 2'd3;

    localparam logic [7:0]  SLAVE_ADDR = 8'h01;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam int          MIN_FRAME  = 7;
    localparam int          CRC_BYTES  = 6;
    localparam logic [2:0]  LAST_BEAT  = 3'd7;
    localparam int          TEMP_READS = 6;
    localparam logic [2:0]  TEMP_LAST  = 3'd5;

    typedef struct packed {
        logic clr_en;
        logic take_any;
        logic take_send;
        logic rx_wr;
        logic tx_load;
        logic walk_issue;
        logic chk_save;
        logic copy_issue;
        logic temp_issue;
        logic rep_load;
    } mrfe_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_free;
        logic tx_last_beat;
        logic short_frame;
        logic walk_last;
        logic copy_ok;
        logic copy_last;
        logic temp_last;
    } mrfe_sts_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Store offsets of the high and low bytes of the three temperatures.
    function automatic logic [3:0] temp_addr(input logic [2:0] idx);
        logic [3:0] a;
        unique case (idx)
            3'd0:    a = 4'd0;
            3'd1:    a = 4'd1;
            3'd2:    a = 4'd4;
            3'd3:    a = 4'd5;
            3'd4:    a = 4'd8;
            3'd5:    a = 4'd9;
            default: a = 4'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// File: src/modbus_rtu_master_frame_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Modbus RTU master frame engine
// Builds request frames with CRC-16, buffers reply bytes, checks a reply
// and copies a good parameter reply into the parameter store.
// ----------------------------------------------------------------------------
// After reset the engine clears the receive buffer and the parameter store,
// one entry of each per cycle, while s_ready stays low. A received byte is
// written into the receive buffer while it has room, and the engine stays
// ready. A send request is accepted and then gives eight beats, one per cycle
// while the output is taken. A frame end walks the received bytes through the
// single buffer read port, one byte per cycle, copies a good parameter reply
// into the store, reads the six temperature bytes from the store, then gives
// one report beat. A reply shorter than seven bytes skips the walk and goes
// straight to its check.
module modbus_rtu_master_frame_engine #(
    parameter int RX_DEPTH    = 256,
    parameter int STORE_DEPTH = 256
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [mrfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_req_type,
    input  wire logic [7:0]                    s_function_code,
    input  wire logic [15:0]                   s_reg_address,
    input  wire logic [15:0]                   s_request_param,
    input  wire logic [7:0]                    s_rx_byte,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_result_kind,
    output logic [7:0]                         m_tx_byte,
    output logic                               m_tx_last,
    output logic [1:0]                         m_frame_status,
    output logic signed [15:0]                 m_temperature_one,
    output logic signed [15:0]                 m_temperature_two,
    output logic signed [15:0]                 m_temperature_three
);

    import mrfe_pkg::*;

    mrfe_cmd_t cmd;
    mrfe_sts_t sts;

    mrfe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_req_type(s_req_type),
        .s_ready   (s_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mrfe_dp #(
        .RX_DEPTH   (RX_DEPTH),
        .STORE_DEPTH(STORE_DEPTH)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_function_code    (s_function_code),
        .s_reg_address      (s_reg_address),
        .s_request_param    (s_request_param),
        .s_rx_byte          (s_rx_byte),
        .cmd                (cmd),
        .sts                (sts),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_result_kind      (m_result_kind),
        .m_tx_byte          (m_tx_byte),
        .m_tx_last          (m_tx_last),
        .m_frame_status     (m_frame_status),
        .m_temperature_one  (m_temperature_one),
        .m_temperature_two  (m_temperature_two),
        .m_temperature_three(m_temperature_three)
    );

endmodule
`default_nettype wire

// File: src/mrfe_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mrfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: src/mrfe_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame engine controller
// Sequences the clearing pass, frame transmission, reply check, copy and
// report through commands to the datapath.
// ----------------------------------------------------------------------------
module mrfe_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic [1:0]         s_req_type,
    output logic                    s_ready,
    input  wire mrfe_pkg::mrfe_sts_t sts,
    output mrfe_pkg::mrfe_cmd_t     cmd
);

    import mrfe_pkg::*;

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_EMIT      = 4'd2;
    localparam logic [3:0] S_WALK      = 4'd3;
    localparam logic [3:0] S_WALK_WAIT = 4'd4;
    localparam logic [3:0] S_CHECK     = 4'd5;
    localparam logic [3:0] S_COPY      = 4'd6;
    localparam logic [3:0] S_COPY_WAIT = 4'd7;
    localparam logic [3:0] S_TEMP      = 4'd8;
    localparam logic [3:0] S_TEMP_WAIT = 4'd9;
    localparam logic [3:0] S_REPORT    = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.take_any = 1'b1;
                    unique case (s_req_type)
                        REQ_SEND: begin
                            cmd.take_send = 1'b1;
                            state_next    = S_EMIT;
                        end
                        REQ_RX: begin
                            cmd.rx_wr = 1'b1;
                        end
                        REQ_END: begin
                            state_next = sts.short_frame ? S_CHECK : S_WALK;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.tx_load = 1'b1;
                    if (sts.tx_last_beat) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_WALK: begin
                cmd.walk_issue = 1'b1;
                if (sts.walk_last) begin
                    state_next = S_WALK_WAIT;
                end
            end
            S_WALK_WAIT: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                cmd.chk_save = 1'b1;
                state_next   = sts.copy_ok ? S_COPY : S_TEMP;
            end
            S_COPY: begin
                cmd.copy_issue = 1'b1;
                if (sts.copy_last) begin
                    state_next = S_COPY_WAIT;
                end
            end
            S_COPY_WAIT: begin
                state_next = S_TEMP;
            end
            S_TEMP: begin
                cmd.temp_issue = 1'b1;
                if (sts.temp_last) begin
                    state_next = S_TEMP_WAIT;
                end
            end
            S_TEMP_WAIT: begin
                state_next = S_REPORT;
            end
            S_REPORT: begin
                if (sts.out_free) begin
                    cmd.rep_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.tx_load || cmd.rep_load) |-> sts.out_free)
        else $error("result loaded while the output register still holds a beat");

    a_send_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_req_type == REQ_SEND) |=> !s_ready)
        else $error("input taken again before the request frame was sent");

    a_copy_good: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK && sts.copy_ok) |-> !sts.short_frame)
        else $error("copy started for a short reply");
`endif

endmodule
`default_nettype wire

// File: src/mrfe_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame engine datapath
// Configuration registers, request state, receive buffer and parameter
// store memories, CRC accumulator, copy and read pointers, output register.
// ----------------------------------------------------------------------------
module mrfe_dp #(
    parameter int RX_DEPTH    = 256,
    parameter int STORE_DEPTH = 256
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [mrfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    input  wire logic [7:0]                    s_function_code,
    input  wire logic [15:0]                   s_reg_address,
    input  wire logic [15:0]                   s_request_param,
    input  wire logic [7:0]                    s_rx_byte,
    input  wire mrfe_pkg::mrfe_cmd_t           cmd,
    output mrfe_pkg::mrfe_sts_t                sts,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_result_kind,
    output logic [7:0]                         m_tx_byte,
    output logic                               m_tx_last,
    output logic [1:0]                         m_frame_status,
    output logic signed [15:0]                 m_temperature_one,
    output logic signed [15:0]                 m_temperature_two,
    output logic signed [15:0]                 m_temperature_three
);

    import mrfe_pkg::*;

    localparam int RX_AW     = $clog2(RX_DEPTH);
    localparam int ST_AW     = $clog2(STORE_DEPTH);
    localparam int CNT_W     = $clog2(RX_DEPTH + 1);
    localparam int CLR_DEPTH = (RX_DEPTH > STORE_DEPTH) ? RX_DEPTH : STORE_DEPTH;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);
    localparam int CI_W      = ST_AW;
    localparam int SRC_W     = ((CI_W > RX_AW) ? CI_W : RX_AW) + 2;
    localparam int DST_W     = ((ST_AW > 8) ? ST_AW : 8) + 1;

    logic [7:0]        read_param_reg;
    logic [7:0]        read_status_reg;
    logic [7:0]        pend_fn_reg;
    logic [7:0]        pend_off_reg;
    logic [15:0]       pend_len_reg;
    logic [7:0]        addr_hi_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CLR_AW-1:0] clr_cnt_reg;

    logic [15:0]       crc_reg;
    logic [2:0]        k_reg;
    logic [CNT_W-1:0]  ptr_reg;
    logic              wv_reg;
    logic [CNT_W-1:0]  widx_reg;
    logic [7:0]        fbyte_reg;
    logic [7:0]        b_prev_reg;
    logic [7:0]        b_last_reg;
    logic [1:0]        stat_reg;
    logic [CI_W-1:0]   ci_reg;
    logic              cv_reg;
    logic [ST_AW-1:0]  cdst_reg;
    logic              czero_reg;
    logic [2:0]        tcnt_reg;
    logic              tv_reg;
    logic [2:0]        tidx_reg;
    logic [7:0]        tb_reg [TEMP_READS];

    logic              m_valid_reg;
    logic              kind_reg;
    logic [7:0]        txb_reg;
    logic              txl_reg;
    logic [1:0]        fst_reg;
    logic [15:0]       t1_reg;
    logic [15:0]       t2_reg;
    logic [15:0]       t3_reg;

    logic [7:0]        tx_cur;
    logic              rx_room;
    logic              clr_rx;
    logic              clr_st;
    logic              func_ok;
    logic              crc_ok;
    logic              short_frame;
    logic [1:0]        code_now;
    logic [SRC_W-1:0]  src;
    logic [DST_W-1:0]  dst;

    logic              buf_we;
    logic [RX_AW-1:0]  buf_waddr;
    logic [7:0]        buf_wdata;
    logic [RX_AW-1:0]  buf_raddr;
    logic [7:0]        buf_rdata;
    logic              st_we;
    logic [ST_AW-1:0]  st_waddr;
    logic [7:0]        st_wdata;
    logic [ST_AW-1:0]  st_raddr;
    logic [7:0]        st_rdata;

    always_comb begin
        case (k_reg)
            3'd0: tx_cur = SLAVE_ADDR;
            3'd1: tx_cur = pend_fn_reg;
            3'd2: tx_cur = addr_hi_reg;
            3'd3: tx_cur = pend_off_reg;
            3'd4: tx_cur = pend_len_reg[15:8];
            3'd5: tx_cur = pend_len_reg[7:0];
            3'd6: tx_cur = crc_reg[7:0];
            3'd7: tx_cur = crc_reg[15:8];
        endcase
    end

    assign rx_room     = (count_reg < CNT_W'(RX_DEPTH));
    assign clr_rx      = ({1'b0, clr_cnt_reg} < (CLR_AW + 1)'(RX_DEPTH));
    assign clr_st      = ({1'b0, clr_cnt_reg} < (CLR_AW + 1)'(STORE_DEPTH));
    assign short_frame = (count_reg < CNT_W'(MIN_FRAME));
    assign func_ok     = (pend_fn_reg == read_param_reg && fbyte_reg == read_param_reg) ||
                         (pend_fn_reg == read_status_reg && fbyte_reg == read_status_reg);
    assign crc_ok      = (b_last_reg == crc_reg[15:8]) && (b_prev_reg == crc_reg[7:0]);

    always_comb begin
        if (short_frame) begin
            code_now = ST_SHORT;
        end else if (!func_ok) begin
            code_now = ST_FUNC;
        end else if (!crc_ok) begin
            code_now = ST_CRC;
        end else begin
            code_now = ST_OK;
        end
    end

    assign src = SRC_W'(ci_reg) + SRC_W'(3);
    assign dst = DST_W'(pend_off_reg) + DST_W'(ci_reg);

    assign sts.clr_last     = (clr_cnt_reg == CLR_AW'(CLR_DEPTH - 1));
    assign sts.out_free     = !m_valid_reg || m_ready;
    assign sts.tx_last_beat = (k_reg == LAST_BEAT);
    assign sts.short_frame  = short_frame;
    assign sts.walk_last    = (ptr_reg == count_reg - CNT_W'(1));
    assign sts.copy_ok      = (code_now == ST_OK) && (pend_fn_reg == read_param_reg) &&
                              (pend_len_reg != 16'd0) &&
                              ((17'(pend_off_reg) + 17'(pend_len_reg)) < 17'(STORE_DEPTH));
    assign sts.copy_last    = (16'(ci_reg) == pend_len_reg - 16'd1);
    assign sts.temp_last    = (tcnt_reg == TEMP_LAST);

    assign buf_we    = (cmd.clr_en && clr_rx) || (cmd.rx_wr && rx_room);
    assign buf_waddr = cmd.clr_en ? clr_cnt_reg[RX_AW-1:0] : count_reg[RX_AW-1:0];
    assign buf_wdata = cmd.clr_en ? 8'h00 : s_rx_byte;
    assign buf_raddr = cmd.copy_issue ? src[RX_AW-1:0] : ptr_reg[RX_AW-1:0];

    assign st_we    = (cmd.clr_en && clr_st) || cv_reg;
    assign st_waddr = cmd.clr_en ? clr_cnt_reg[ST_AW-1:0] : cdst_reg;
    assign st_wdata = (cmd.clr_en || czero_reg) ? 8'h00 : buf_rdata;
    assign st_raddr = ST_AW'(temp_addr(tcnt_reg));

    mrfe_ram #(
        .WIDTH(8),
        .DEPTH(RX_DEPTH)
    ) u_rx_buf (
        .aclk (aclk),
        .we   (buf_we),
        .waddr(buf_waddr),
        .wdata(buf_wdata),
        .raddr(buf_raddr),
        .rdata(buf_rdata)
    );

    mrfe_ram #(
        .WIDTH(8),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (st_we),
        .waddr(st_waddr),
        .wdata(st_wdata),
        .raddr(st_raddr),
        .rdata(st_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_param_reg  <= READ_PARAM_RESET;
            read_status_reg <= READ_STATUS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_READ_PARAM:  read_param_reg  <= cfg_data;
                CFG_READ_STATUS: read_status_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_fn_reg  <= '0;
            pend_off_reg <= '0;
            pend_len_reg <= '0;
            count_reg    <= '0;
            clr_cnt_reg  <= '0;
            wv_reg       <= 1'b0;
            cv_reg       <= 1'b0;
            tv_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            wv_reg <= cmd.walk_issue;
            cv_reg <= cmd.copy_issue;
            tv_reg <= cmd.temp_issue;
            if (cmd.clr_en) begin
                clr_cnt_reg <= clr_cnt_reg + CLR_AW'(1);
            end
            if (cmd.take_send) begin
                pend_fn_reg  <= s_function_code;
                pend_off_reg <= s_reg_address[7:0];
                pend_len_reg <= s_request_param;
                count_reg    <= '0;
            end else if (cmd.rx_wr && rx_room) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.tx_load || cmd.rep_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_any) begin
            crc_reg  <= CRC_INIT;
            k_reg    <= '0;
            ptr_reg  <= '0;
            ci_reg   <= '0;
            tcnt_reg <= '0;
        end else begin
            if (cmd.tx_load) begin
                k_reg <= k_reg + 3'd1;
                if (32'(k_reg) < CRC_BYTES) begin
                    crc_reg <= crc_feed(crc_reg, tx_cur);
                end
            end
            if (wv_reg && ({1'b0, widx_reg} + (CNT_W + 1)'(2)) < {1'b0, count_reg}) begin
                crc_reg <= crc_feed(crc_reg, buf_rdata);
            end
            if (cmd.walk_issue) begin
                ptr_reg <= ptr_reg + CNT_W'(1);
            end
            if (cmd.copy_issue) begin
                ci_reg <= ci_reg + CI_W'(1);
            end
            if (cmd.temp_issue) begin
                tcnt_reg <= tcnt_reg + 3'd1;
            end
        end
        if (cmd.take_send) begin
            addr_hi_reg <= s_reg_address[15:8];
        end
        if (cmd.walk_issue) begin
            widx_reg <= ptr_reg;
        end
        if (wv_reg) begin
            if (widx_reg == CNT_W'(1)) begin
                fbyte_reg <= buf_rdata;
            end
            b_prev_reg <= b_last_reg;
            b_last_reg <= buf_rdata;
        end
        if (cmd.chk_save) begin
            stat_reg <= code_now;
        end
        if (cmd.copy_issue) begin
            cdst_reg  <= dst[ST_AW-1:0];
            czero_reg <= (src >= SRC_W'(RX_DEPTH));
        end
        if (cmd.temp_issue) begin
            tidx_reg <= tcnt_reg;
        end
        if (tv_reg) begin
            tb_reg[tidx_reg] <= st_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tx_load) begin
            kind_reg <= RES_TX;
            txb_reg  <= tx_cur;
            txl_reg  <= (k_reg == LAST_BEAT);
            fst_reg  <= ST_OK;
            t1_reg   <= '0;
            t2_reg   <= '0;
            t3_reg   <= '0;
        end else if (cmd.rep_load) begin
            kind_reg <= RES_REPORT;
            txb_reg  <= '0;
            txl_reg  <= 1'b0;
            fst_reg  <= stat_reg;
            t1_reg   <= {tb_reg[0], tb_reg[1]};
            t2_reg   <= {tb_reg[2], tb_reg[3]};
            t3_reg   <= {tb_reg[4], tb_reg[5]};
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_result_kind       = kind_reg;
    assign m_tx_byte           = txb_reg;
    assign m_tx_last           = txl_reg;
    assign m_frame_status      = fst_reg;
    assign m_temperature_one   = t1_reg;
    assign m_temperature_two   = t2_reg;
    assign m_temperature_three = t3_reg;

`ifndef ASSERT_OFF
    a_copy_src_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cv_reg |-> !cmd.clr_en)
        else $error("store copy write collides with the clearing pass");

    a_rx_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rx_wr && !rx_room) |=> (count_reg == CNT_W'(RX_DEPTH)))
        else $error("receive count moved past the buffer depth");

    a_beat_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_tx_last) |-> (m_result_kind == RES_TX))
        else $error("last-byte flag set on a report beat");
`endif

endmodule
`default_nettype wire

// File: sim/mrfe_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU master frame engine checker
// Watches the configuration port and both channels of the engine. It keeps
// its own copy of the engine state to work out the transmit and report beats
// of every accepted request. It compares each result beat with the oldest
// outstanding one and counts the mismatches for the testbench top.
// ----------------------------------------------------------------------------
module mrfe_frame_checker #(
    parameter int RX_DEPTH    = 256,
    parameter int STORE_DEPTH = 256
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [mrfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                     cfg_data,
    input  wire logic                           s_valid,
    input  wire logic                           s_ready,
    input  wire logic [1:0]                     s_req_type,
    input  wire logic [7:0]                     s_function_code,
    input  wire logic [15:0]                    s_reg_address,
    input  wire logic [15:0]                    s_request_param,
    input  wire logic [7:0]                     s_rx_byte,
    input  wire logic                           m_valid,
    input  wire logic                           m_ready,
    input  wire logic                           m_result_kind,
    input  wire logic [7:0]                     m_tx_byte,
    input  wire logic                           m_tx_last,
    input  wire logic [1:0]                     m_frame_status,
    input  wire logic signed [15:0]             m_temperature_one,
    input  wire logic signed [15:0]             m_temperature_two,
    input  wire logic signed [15:0]             m_temperature_three,
    output int                                  fail_count,
    output int                                  pending_count
);
    import mrfe_pkg::*;

    typedef struct packed {
        logic               kind;
        logic [7:0]         tx_byte;
        logic               tx_last;
        logic [1:0]         status;
        logic signed [15:0] temp_one;
        logic signed [15:0] temp_two;
        logic signed [15:0] temp_three;
    } engine_beat_t;

    logic [7:0]   param_code;
    logic [7:0]   status_code;
    logic [7:0]   rx_buf [0:RX_DEPTH-1];
    int           rx_count;
    logic [7:0]   pend_fc;
    logic [7:0]   pend_off;
    logic [15:0]  pend_len;
    logic [7:0]   param_store [0:STORE_DEPTH-1];
    engine_beat_t out_beats_q [$];
    engine_beat_t want_beat;

    function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc,
                                                    input logic [7:0] data);
        logic [15:0] c;
        int          k;
        c = crc ^ {8'h00, data};
        for (k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ 16'hA001;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Judges the buffered reply and copies a good parameter reply to the store.
    task automatic judge_reply(output logic [1:0] status);
        logic [15:0] crc;
        logic [7:0]  func;
        int          i;
        crc  = 16'hFFFF;
        func = rx_buf[1];
        if (rx_count < 7) begin
            status = ST_SHORT;
        end else if (!((pend_fc == param_code && func == param_code) ||
                       (pend_fc == status_code && func == status_code))) begin
            status = ST_FUNC;
        end else begin
            for (i = 0; i + 2 < rx_count; i++) begin
                crc = modbus_crc_step(crc, rx_buf[i]);
            end
            if (rx_buf[rx_count-1] != crc[15:8] || rx_buf[rx_count-2] != crc[7:0]) begin
                status = ST_CRC;
            end else begin
                status = ST_OK;
                if (pend_fc == param_code &&
                    int'(pend_off) + int'(pend_len) < STORE_DEPTH) begin
                    for (i = 0; i < int'(pend_len); i++) begin
                        param_store[int'(pend_off) + i] =
                            (i + 3 < RX_DEPTH) ? rx_buf[i + 3] : 8'h00;
                    end
                end
            end
        end
    endtask

    task automatic engine_step(input logic [1:0] req, input logic [7:0] fc,
                               input logic [15:0] addr, input logic [15:0] par,
                               input logic [7:0] rxb);
        logic [7:0]   frame [0:7];
        logic [15:0]  crc;
        logic [1:0]   status;
        engine_beat_t beat;
        int           k;
        beat = '0;
        case (req)
            REQ_SEND: begin
                frame[0] = 8'h01;
                frame[1] = fc;
                frame[2] = addr[15:8];
                frame[3] = addr[7:0];
                frame[4] = par[15:8];
                frame[5] = par[7:0];
                crc = 16'hFFFF;
                for (k = 0; k < 6; k++) begin
                    crc = modbus_crc_step(crc, frame[k]);
                end
                frame[6] = crc[7:0];
                frame[7] = crc[15:8];
                for (k = 0; k < 8; k++) begin
                    beat.kind    = RES_TX;
                    beat.tx_byte = frame[k];
                    beat.tx_last = (k == 7);
                    out_beats_q.push_back(beat);
                end
                pend_fc  = fc;
                pend_off = addr[7:0];
                pend_len = par;
                rx_count = 0;
            end
            REQ_RX: begin
                if (rx_count < RX_DEPTH) begin
                    rx_buf[rx_count] = rxb;
                    rx_count++;
                end
            end
            REQ_END: begin
                judge_reply(status);
                beat.kind       = RES_REPORT;
                beat.status     = status;
                beat.temp_one   = {param_store[0], param_store[1]};
                beat.temp_two   = {param_store[4], param_store[5]};
                beat.temp_three = {param_store[8], param_store[9]};
                out_beats_q.push_back(beat);
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_field(input string field, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s expected %0d actual %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            param_code  = READ_PARAM_RESET;
            status_code = READ_STATUS_RESET;
            for (int i = 0; i < RX_DEPTH; i++) begin
                rx_buf[i] = 8'h00;
            end
            for (int i = 0; i < STORE_DEPTH; i++) begin
                param_store[i] = 8'h00;
            end
            rx_count   = 0;
            pend_fc    = 8'h00;
            pend_off   = 8'h00;
            pend_len   = 16'h0000;
            fail_count = 0;
            out_beats_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_READ_PARAM) begin
                    param_code = cfg_data;
                end else if (cfg_index == CFG_READ_STATUS) begin
                    status_code = cfg_data;
                end
            end
            if (m_valid && m_ready) begin
                if (out_beats_q.size() == 0) begin
                    $error("result beat arrived with no beat outstanding");
                    fail_count++;
                end else begin
                    want_beat = out_beats_q.pop_front();
                    check_field("result_kind", want_beat.kind, m_result_kind);
                    check_field("tx_byte", want_beat.tx_byte, m_tx_byte);
                    check_field("tx_last", want_beat.tx_last, m_tx_last);
                    check_field("frame_status", want_beat.status, m_frame_status);
                    check_field("temperature_one", want_beat.temp_one, m_temperature_one);
                    check_field("temperature_two", want_beat.temp_two, m_temperature_two);
                    check_field("temperature_three", want_beat.temp_three,
                                m_temperature_three);
                end
            end
            if (s_valid && s_ready) begin
                engine_step(s_req_type, s_function_code, s_reg_address,
                            s_request_param, s_rx_byte);
            end
        end
        pending_count = out_beats_q.size();
    end

endmodule

// File: sim/tb_modbus_rtu_master_frame_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU master frame engine testbench
// Drives send requests, reply bytes and frame ends into the engine under
// changing function code settings and handshake pressure. It builds well
// formed replies that are mostly intact and sometimes damaged, and mixes in
// random noise. The checker beside the engine judges every result beat.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_master_frame_engine;
    import mrfe_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 12;
    localparam int RX_DEPTH     = 256;
    localparam int STORE_DEPTH  = 256;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int QUIET_CYCLES = 16;
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASE_ITEMS  = 16;
    localparam int NUM_PHASES   = 5;
    localparam int REPLY_MAX    = 264;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef enum int {
        MANGLE_NONE,
        MANGLE_BIT,
        MANGLE_FUNC,
        MANGLE_SHORT,
        MANGLE_JUNK
    } mangle_e;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    logic [7:0]           cfg_data        = 8'h00;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_req_type      = REQ_SEND;
    logic [7:0]           s_function_code = 8'h00;
    logic [15:0]          s_reg_address   = 16'h0000;
    logic [15:0]          s_request_param = 16'h0000;
    logic [7:0]           s_rx_byte       = 8'h00;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic                 m_result_kind;
    logic [7:0]           m_tx_byte;
    logic                 m_tx_last;
    logic [1:0]           m_frame_status;
    logic signed [15:0]   m_temperature_one;
    logic signed [15:0]   m_temperature_two;
    logic signed [15:0]   m_temperature_three;

    int         fail_count;
    int         pending_count;
    int         cycle_count   = 0;
    int         counted_items = 0;
    int         idle_pct      = 0;
    int         stall_pct     = 0;
    logic [7:0] param_code    = READ_PARAM_RESET;
    logic [7:0] status_code   = READ_STATUS_RESET;

    modbus_rtu_master_frame_engine #(
        .RX_DEPTH    (RX_DEPTH),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_req_type          (s_req_type),
        .s_function_code     (s_function_code),
        .s_reg_address       (s_reg_address),
        .s_request_param     (s_request_param),
        .s_rx_byte           (s_rx_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_result_kind       (m_result_kind),
        .m_tx_byte           (m_tx_byte),
        .m_tx_last           (m_tx_last),
        .m_frame_status      (m_frame_status),
        .m_temperature_one   (m_temperature_one),
        .m_temperature_two   (m_temperature_two),
        .m_temperature_three (m_temperature_three)
    );

    mrfe_frame_checker #(
        .RX_DEPTH    (RX_DEPTH),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_req_type          (s_req_type),
        .s_function_code     (s_function_code),
        .s_reg_address       (s_reg_address),
        .s_request_param     (s_request_param),
        .s_rx_byte           (s_rx_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_result_kind       (m_result_kind),
        .m_tx_byte           (m_tx_byte),
        .m_tx_last           (m_tx_last),
        .m_frame_status      (m_frame_status),
        .m_temperature_one   (m_temperature_one),
        .m_temperature_two   (m_temperature_two),
        .m_temperature_three (m_temperature_three),
        .fail_count          (fail_count),
        .pending_count       (pending_count)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("modbus_rtu_master_frame_engine test failed");
            $finish;
        end
    end

    task automatic push_beat(input logic [1:0] req, input logic [7:0] fc,
                             input logic [15:0] addr, input logic [15:0] par,
                             input logic [7:0] rxb, input bit counted);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_req_type      <= req;
        s_function_code <= fc;
        s_reg_address   <= addr;
        s_request_param <= par;
        s_rx_byte       <= rxb;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (counted) begin
            counted_items++;
        end
    endtask

    task automatic push_rx(input logic [7:0] rxb, input bit counted);
        push_beat(REQ_RX, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                  16'($urandom_range(65535)), rxb, counted);
    endtask

    task automatic push_end();
        push_beat(REQ_END, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                  16'($urandom_range(65535)), 8'($urandom_range(255)), 1'b1);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_READ_PARAM) begin
            param_code = data;
        end else begin
            status_code = data;
        end
    endtask

    task automatic wait_quiet();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (QUIET_CYCLES) @(negedge aclk);
    endtask

    // Slave reply: address, function, byte count, data, then CRC low and high.
    task automatic send_reply(input logic [7:0] fc, input int data_len,
                              input mangle_e mangle, input int extra);
        logic [7:0]  frame [0:REPLY_MAX-1];
        logic [15:0] crc;
        int          n;
        int          pos;
        int          i;
        n        = data_len + 5;
        frame[0] = SLAVE_ADDR;
        frame[1] = fc;
        frame[2] = data_len[7:0];
        for (i = 3; i < n - 2; i++) begin
            frame[i] = 8'($urandom_range(255));
        end
        crc = 16'hFFFF;
        for (i = 0; i < n - 2; i++) begin
            crc = crc_feed(crc, frame[i]);
        end
        frame[n-2] = crc[7:0];
        frame[n-1] = crc[15:8];
        case (mangle)
            MANGLE_BIT: begin
                pos        = $urandom_range(n - 1);
                frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(7));
            end
            MANGLE_FUNC: begin
                frame[1] = 8'($urandom_range(255));
            end
            MANGLE_SHORT: begin
                n = $urandom_range(6);
            end
            MANGLE_JUNK: begin
                for (i = 0; i < n; i++) begin
                    frame[i] = 8'($urandom_range(255));
                end
            end
            default: begin
            end
        endcase
        for (i = 0; i < n; i++) begin
            push_rx(frame[i], 1'b1);
        end
        for (i = 0; i < extra; i++) begin
            push_rx(8'($urandom_range(255)), 1'b0);
        end
    endtask

    task automatic run_exchange(input bit overflow);
        logic [7:0] fc;
        logic [7:0] addr_hi;
        int         off;
        int         len;
        int         pick;
        mangle_e    mangle;
        pick = $urandom_range(99);
        if (pick < 45) begin
            fc = param_code;
        end else if (pick < 80) begin
            fc = status_code;
        end else begin
            fc = 8'($urandom_range(255));
        end
        pick = $urandom_range(99);
        if (pick < 85) begin
            off = ($urandom_range(99) < 60) ? $urandom_range(12) : $urandom_range(255);
            len = $urandom_range(16);
        end else if (pick < 95) begin
            off = $urandom_range(255);
            len = $urandom_range(80);
        end else begin
            off = $urandom_range(3);
            len = STORE_DEPTH - off - $urandom_range(2);
        end
        addr_hi = 8'($urandom_range(255));
        push_beat(REQ_SEND, fc, {addr_hi, off[7:0]}, len[15:0],
                  8'($urandom_range(255)), 1'b1);
        pick = $urandom_range(99);
        if (pick < 70) begin
            mangle = MANGLE_NONE;
        end else if (pick < 78) begin
            mangle = MANGLE_BIT;
        end else if (pick < 86) begin
            mangle = MANGLE_FUNC;
        end else if (pick < 94) begin
            mangle = MANGLE_SHORT;
        end else begin
            mangle = MANGLE_JUNK;
        end
        if (overflow) begin
            send_reply(fc, RX_DEPTH - 5, MANGLE_NONE, 3);
        end else begin
            send_reply(fc, $urandom_range(2, 24), mangle, 0);
        end
        push_end();
    endtask

    task automatic push_noise();
        logic [1:0] req;
        req = 2'($urandom_range(3));
        push_beat(req, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                  16'($urandom_range(65535)), 8'($urandom_range(255)),
                  req != REQ_UNUSED);
    endtask

    initial begin
        int  phase;
        int  goal;
        int  seq;
        bit  overflow_done;
        seq           = 0;
        overflow_done = 1'b0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        push_beat(REQ_SEND, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1);
        push_beat(REQ_SEND, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
        push_end();
        push_beat(REQ_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
        push_rx(8'h00, 1'b1);
        push_rx(8'hFF, 1'b1);
        push_end();
        push_beat(REQ_SEND, param_code, 16'h0000, 16'd10, 8'h00, 1'b1);
        send_reply(param_code, 10, MANGLE_NONE, 0);
        push_end();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            wait_quiet();
            case (phase)
                1: begin
                    write_reg(CFG_READ_PARAM, 8'hFF);
                    write_reg(CFG_READ_STATUS, 8'h00);
                end
                2: begin
                    write_reg(CFG_READ_PARAM, 8'h04);
                    write_reg(CFG_READ_STATUS, 8'h04);
                end
                3: begin
                    write_reg(CFG_READ_PARAM, 8'($urandom_range(255)));
                    write_reg(CFG_READ_STATUS, 8'($urandom_range(255)));
                end
                4: begin
                    write_reg(CFG_READ_PARAM, READ_PARAM_RESET);
                    write_reg(CFG_READ_STATUS, READ_STATUS_RESET);
                end
                default: begin
                end
            endcase
            goal = counted_items + PHASE_ITEMS;
            while (counted_items < goal) begin
                case (seq % 4)
                    0: begin
                        idle_pct  = 0;
                        stall_pct = 0;
                    end
                    1: begin
                        idle_pct  = 75;
                        stall_pct = 0;
                    end
                    2: begin
                        idle_pct  = 0;
                        stall_pct = 75;
                    end
                    default: begin
                        idle_pct  = 27;
                        stall_pct = 27;
                    end
                endcase
                if (phase == 2 && !overflow_done) begin
                    run_exchange(1'b1);
                    overflow_done = 1'b1;
                end else if ($urandom_range(99) < 75) begin
                    run_exchange(1'b0);
                end else begin
                    repeat ($urandom_range(1, 4)) push_noise();
                end
                seq++;
                if ($urandom_range(9) == 0) begin
                    wait_quiet();
                end
            end
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("modbus_rtu_master_frame_engine test passed");
        end else begin
            $display("modbus_rtu_master_frame_engine test failed");
        end
        $finish;
    end

endmodule
